>>> rtl/core/adte_pkg.sv
package adte_pkg;

	localparam logic [4:0] POS_LAST       = 5'd18;
	localparam logic [4:0] POS_YEAR_END   = 5'd3;
	localparam logic [4:0] POS_MONTH_END  = 5'd6;
	localparam logic [4:0] POS_DAY_END    = 5'd9;
	localparam logic [4:0] POS_HOUR_END   = 5'd12;
	localparam logic [4:0] POS_MINUTE_END = 5'd15;

	localparam int unsigned FIFO_AW    = 1;
	localparam int unsigned FIFO_DEPTH = 2 ** FIFO_AW;

	localparam logic [6:0]  RECIP12    = 7'd43;
	localparam int unsigned RECIP12_SH = 9;
	localparam logic [12:0] RECIP100    = 13'd5243;
	localparam int unsigned RECIP100_SH = 19;
	localparam logic [19:0] DAYS_1970   = 20'd719162;
	localparam logic [5:0]  SEC_MAX     = 6'd59;

	typedef struct packed {
		logic [7:0] char_code;
		logic       start_of_text;
	} in_item_t;

	typedef struct packed {
		logic signed [38:0] epoch_seconds;
		logic               status;
	} out_item_t;

	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [5:0]  second;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic is_separator(input logic [4:0] pos);
		return (pos == 5'd4) || (pos == 5'd7) || (pos == 5'd10) || (pos == 5'd13)
			|| (pos == 5'd16);
	endfunction

	function automatic logic is_field_start(input logic [4:0] pos);
		return (pos == 5'd0) || (pos == 5'd5) || (pos == 5'd8) || (pos == 5'd11)
			|| (pos == 5'd14) || (pos == 5'd17);
	endfunction

	function automatic logic [8:0] days_before_month(input logic leap, input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		if (leap && (m >= 4'd2)) begin
			d = d + 9'd1;
		end
		return d;
	endfunction

endpackage

>>> rtl/core/adte_front.sv
module adte_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_ready,
	input  adte_pkg::in_item_t char_item,
	input  adte_pkg::fifo_stat_t stat,
	output logic               push,
	output adte_pkg::rec_t     push_rec
);

	logic [4:0]  pos_q;
	logic [13:0] acc_q;
	logic        stopped_q;
	logic [13:0] year_q;
	logic [6:0]  month_q;
	logic [6:0]  day_q;
	logic [6:0]  hour_q;
	logic [6:0]  minute_q;

	logic        fire;
	logic [4:0]  pos;
	logic        digit;
	logic        take;
	logic [13:0] acc_base;
	logic        stop_base;
	logic [13:0] acc_nxt;
	logic        stop_nxt;
	logic [5:0]  sec;

	assign char_ready = !stat.full;
	assign fire       = char_valid && char_ready;

	always_comb begin
		pos       = char_item.start_of_text ? 5'd0 : pos_q;
		digit     = (char_item.char_code >= 8'h30) && (char_item.char_code <= 8'h39);
		acc_base  = adte_pkg::is_field_start(pos) ? 14'd0 : acc_q;
		stop_base = adte_pkg::is_field_start(pos) ? 1'b0 : stopped_q;
		take      = !stop_base && digit;
		acc_nxt   = take ? (acc_base * 14'd10 + {10'd0, char_item.char_code[3:0]}) : acc_base;
		stop_nxt  = stop_base || !take;
		sec       = (acc_nxt > 14'(adte_pkg::SEC_MAX)) ? adte_pkg::SEC_MAX : acc_nxt[5:0];
	end

	assign push = fire && (pos == adte_pkg::POS_LAST);

	always_comb begin
		push_rec.year   = year_q;
		push_rec.month  = month_q;
		push_rec.day    = day_q;
		push_rec.hour   = hour_q;
		push_rec.minute = minute_q;
		push_rec.second = sec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 5'd0;
			acc_q     <= 14'd0;
			stopped_q <= 1'b0;
			year_q    <= 14'd0;
			month_q   <= 7'd0;
			day_q     <= 7'd0;
			hour_q    <= 7'd0;
			minute_q  <= 7'd0;
		end else if (fire) begin
			if (adte_pkg::is_separator(pos)) begin
				pos_q <= pos + 5'd1;
			end else begin
				acc_q     <= acc_nxt;
				stopped_q <= stop_nxt;
				pos_q     <= (pos == adte_pkg::POS_LAST) ? 5'd0 : pos + 5'd1;
				if (pos == adte_pkg::POS_YEAR_END) begin
					year_q <= acc_nxt;
				end
				if (pos == adte_pkg::POS_MONTH_END) begin
					month_q <= acc_nxt[6:0];
				end
				if (pos == adte_pkg::POS_DAY_END) begin
					day_q <= acc_nxt[6:0];
				end
				if (pos == adte_pkg::POS_HOUR_END) begin
					hour_q <= acc_nxt[6:0];
				end
				if (pos == adte_pkg::POS_MINUTE_END) begin
					minute_q <= acc_nxt[6:0];
				end
			end
		end
	end

endmodule

>>> rtl/core/adte_fifo.sv
module adte_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  adte_pkg::rec_t       push_rec,
	input  logic                 pop,
	output adte_pkg::rec_t       pop_rec,
	output adte_pkg::fifo_stat_t stat
);

	adte_pkg::rec_t                 mem_q [adte_pkg::FIFO_DEPTH];
	logic [adte_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [adte_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [adte_pkg::FIFO_AW:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	assign stat.full  = (count_q == (adte_pkg::FIFO_AW + 1)'(adte_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_rec    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/adte_back.sv
module adte_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  adte_pkg::fifo_stat_t stat,
	output logic                 pop,
	input  adte_pkg::rec_t       pop_rec,
	output logic                 result_valid,
	input  logic                 result_ready,
	output adte_pkg::out_item_t  result_item
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_DIV12 = 9'b000000010,
		ST_YEAR  = 9'b000000100,
		ST_CENT  = 9'b000001000,
		ST_LEAP  = 9'b000010000,
		ST_DAYS  = 9'b000100000,
		ST_HOURS = 9'b001000000,
		ST_MINS  = 9'b010000000,
		ST_SECS  = 9'b100000000
	} state_t;

	state_t         state_q;
	adte_pkg::rec_t rec_q;
	logic [6:0]     mon_q;
	logic [3:0]     q12_q;
	logic [3:0]     r12_q;
	logic [13:0]    y_q;
	logic [7:0]     q100_q;
	logic [13:0]    p_q;
	logic [12:0]    leapdays_q;
	logic [9:0]     yday_q;
	logic [23:0]    days_q;
	logic [27:0]    hours_q;
	logic [33:0]    mins_q;
	logic           out_valid_q;
	adte_pkg::out_item_t out_q;

	logic [6:0]  mon;
	logic [12:0] prod12;
	logic [26:0] prod100;
	logic [13:0] r100;
	logic        cent;
	logic        leap;
	logic [7:0]  q100p;
	logic [27:0] days_x;
	logic [33:0] hours_x;
	logic [38:0] mins_x;
	logic [38:0] secs;
	logic        err;
	logic        done;

	assign pop          = (state_q == ST_IDLE) && !stat.empty;
	assign result_valid = out_valid_q;
	assign result_item  = out_q;
	assign done         = (state_q == ST_SECS) && (!out_valid_q || result_ready);

	always_comb begin
		mon     = rec_q.month - 7'd1;
		prod12  = 13'(mon) * 13'(adte_pkg::RECIP12);
		prod100 = 27'(y_q) * 27'(adte_pkg::RECIP100);
		r100    = y_q - 14'(q100_q) * 14'd100;
		cent    = (r100 == 14'd0);
		leap    = (y_q[1:0] == 2'd0) && (!cent || (q100_q[1:0] == 2'd0));
		q100p   = q100_q - {7'd0, cent};
		days_x  = {{4{days_q[23]}}, days_q};
		hours_x = {{6{hours_q[27]}}, hours_q};
		mins_x  = {{5{mins_q[33]}}, mins_q};
		secs    = (mins_x << 6) - (mins_x << 2) + 39'(rec_q.second);
		err     = (rec_q.year == 14'd0) || (rec_q.month == 7'd0) || (rec_q.day == 7'd0);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					rec_q <= pop_rec;
				end
			end
			ST_DIV12: begin
				mon_q <= mon;
				q12_q <= prod12[adte_pkg::RECIP12_SH +: 4];
			end
			ST_YEAR: begin
				r12_q <= 4'(mon_q - 7'(q12_q) * 7'd12);
				y_q   <= rec_q.year + 14'(q12_q);
			end
			ST_CENT: begin
				q100_q <= prod100[adte_pkg::RECIP100_SH +: 8];
			end
			ST_LEAP: begin
				p_q        <= y_q - 14'd1;
				leapdays_q <= 13'((y_q - 14'd1) >> 2) - 13'(q100p) + 13'(q100p[7:2]);
				yday_q     <= 10'(adte_pkg::days_before_month(leap, r12_q))
					+ 10'(rec_q.day) - 10'd1;
			end
			ST_DAYS: begin
				days_q <= 24'(p_q) * 24'd365 + 24'(leapdays_q) + 24'(yday_q)
					- 24'(adte_pkg::DAYS_1970);
			end
			ST_HOURS: begin
				hours_q <= (days_x << 4) + (days_x << 3) + 28'(rec_q.hour);
			end
			ST_MINS: begin
				mins_q <= (hours_x << 6) - (hours_x << 2) + 34'(rec_q.minute);
			end
			ST_SECS: begin
				if (done) begin
					out_q.epoch_seconds <= err ? 39'sd0 : $signed(secs);
					out_q.status        <= err;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:  state_q <= pop ? ST_DIV12 : ST_IDLE;
				ST_DIV12: state_q <= ST_YEAR;
				ST_YEAR:  state_q <= ST_CENT;
				ST_CENT:  state_q <= ST_LEAP;
				ST_LEAP:  state_q <= ST_DAYS;
				ST_DAYS:  state_q <= ST_HOURS;
				ST_HOURS: state_q <= ST_MINS;
				ST_MINS:  state_q <= ST_SECS;
				ST_SECS:  state_q <= done ? ST_IDLE : ST_SECS;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/ascii_datetime_to_epoch_core.sv
// channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------------
// char      | char_valid / char_ready    | char_item   (char_code, start_of_text)
// result    | result_valid / result_ready| result_item (epoch_seconds, status)
//
// One character is taken per cycle while the queue is not full; a text of 19 characters yields one result.
// The back end works each text through its arithmetic sequencer (one
// multiply or add step per state, DIV12 through SECS).
// A two-entry queue parts parser and sequencer; char_ready drops only when it is full.
// A result waiting in the output register stops parsing only once the queue has filled.
// arst_n clears positions, queue and sequencer; no clearing pass is needed.
module ascii_datetime_to_epoch_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_ready,
	input  adte_pkg::in_item_t  char_item,
	output logic                result_valid,
	input  logic                result_ready,
	output adte_pkg::out_item_t result_item
);

	logic                 push;
	logic                 pop;
	adte_pkg::rec_t       push_rec;
	adte_pkg::rec_t       pop_rec;
	adte_pkg::fifo_stat_t stat;

	adte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.stat       (stat),
		.push       (push),
		.push_rec   (push_rec)
	);

	adte_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.stat     (stat)
	);

	adte_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat         (stat),
		.pop          (pop),
		.pop_rec      (pop_rec),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

endmodule

>>> rtl/core/adte_checker.sv
module adte_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                char_valid,
	input logic                char_ready,
	input adte_pkg::in_item_t  char_item,
	input logic                result_valid,
	input logic                result_ready,
	input adte_pkg::out_item_t result_item
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_item))
		else $error("result changed while stalled");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.status |-> result_item.epoch_seconds == 39'sd0)
		else $error("error result carries nonzero seconds");

	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.status
		|-> result_item.epoch_seconds >= -39'sd62135596800
		&& result_item.epoch_seconds <= 39'sd253700000000)
		else $error("seconds out of range");

	a_char_known: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_ready |-> !$isunknown(char_item))
		else $error("unknown character transferred");

endmodule

bind ascii_datetime_to_epoch_core adte_checker u_adte_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.char_valid   (char_valid),
	.char_ready   (char_ready),
	.char_item    (char_item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_item  (result_item)
);
